>>> rtl/idbu_pkg.sv
package idbu_pkg;

    localparam int WORD_W  = 32;
    localparam int INDEX_W = 13;
    localparam int NUM_REGS = 7;

    // Usage classes
    localparam logic [2:0] CLS_INVALID = 3'd0;
    localparam logic [2:0] CLS_READ_BC = 3'd1;
    localparam logic [2:0] CLS_READ_B  = 3'd2;
    localparam logic [2:0] CLS_READ_AB = 3'd3;
    localparam logic [2:0] CLS_WRITE_A = 3'd4;
    localparam logic [2:0] CLS_READ_A  = 3'd5;
    localparam logic [2:0] CLS_HALT    = 3'd6;

    // Word status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_UNSET    = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // Opcodes and system call extensions
    localparam logic [4:0] OP_LOAD     = 5'd23;
    localparam logic [4:0] OP_STORE    = 5'd24;
    localparam logic [4:0] OP_LOAD_IMM = 5'd25;
    localparam logic [4:0] OP_SYS      = 5'd26;

    localparam logic [2:0] SYS_HALT    = 3'd4;
    localparam logic [2:0] REG_LIMIT   = 3'd6;

    typedef struct packed {
        logic [WORD_W-1:0] instruction_word;
        logic              last_word;
    } word_t;

    typedef struct packed {
        logic [2:0]         usage_class;
        logic [1:0]         word_status;
        logic [INDEX_W-1:0] word_index;
        logic               program_ok;
        logic [INDEX_W-1:0] first_bad_index;
        logic               program_done;
    } result_t;

endpackage

>>> rtl/instruction_def_before_use_checker_unit.sv
// Channel   Dir  Handshake                     Beat
// --------  ---  ----------------------------  ------------------------------
// word      in   word_valid / word_stall       idbu_pkg::word_t (instr, last)
// result    out  result_valid / result_stall   idbu_pkg::result_t
//
// One beat per cycle sustained while result_stall is low. A word passes
// through the input register and then the result register.
// The decode and the 7-bit register map check sit in one combinational step.
// rst_n clears the map, the position count and the failure record at once;
// the same state returns to reset after the result for a last word is formed.
// A stall on the result side holds the result register and a full input
// register; word_stall rises only while that register cannot advance.
module instruction_def_before_use_checker_unit #(
    parameter int MAX_PROGRAM_WORDS = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             word_valid,
    output logic             word_stall,
    input  idbu_pkg::word_t  word,
    output logic             result_valid,
    input  logic             result_stall,
    output idbu_pkg::result_t result
);

    import idbu_pkg::*;

    // Position counter must be able to hold the limit itself.
    localparam int CNT_W = $clog2(MAX_PROGRAM_WORDS + 1);
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_PROGRAM_WORDS);

    // Input stage
    logic  in_valid_reg;
    word_t in_word_reg;

    // Result stage
    logic    out_valid_reg;
    result_t out_reg;

    // Program state
    logic [NUM_REGS-1:0] map_reg, map_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic                failed_reg, failed_next;
    logic [CNT_W-1:0]    first_reg, first_next;

    logic    out_free;
    logic    advance;
    result_t out_next;

    // Decode of the word in the input register
    logic [4:0] op;
    logic [2:0] ext;
    logic [2:0] ra, rb, rc;
    logic       aligned;
    logic [2:0] cls;
    logic       reads_ok;
    logic [1:0] status;
    logic [NUM_REGS:0] marked;       // extra top bit reads as unmarked
    logic [CNT_W+INDEX_W-1:0] idx_wide;
    logic [CNT_W+INDEX_W-1:0] first_wide;

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = in_valid_reg && out_free;
    assign word_stall = in_valid_reg && !out_free;

    assign op      = in_word_reg.instruction_word[31:27];
    assign ext     = in_word_reg.instruction_word[26:24];
    assign ra      = in_word_reg.instruction_word[23:21];
    assign rb      = in_word_reg.instruction_word[20:18];
    assign rc      = in_word_reg.instruction_word[17:15];
    assign aligned = (in_word_reg.instruction_word[1:0] == 2'b00);
    assign marked  = {1'b0, map_reg};

    // Classify by opcode group; register fields above the limit, and write targets at it, are invalid.
    always_comb
    begin
        cls = CLS_INVALID;
        case (op) inside
            [5'd0:5'd4], [5'd7:5'd11], 5'd13, 5'd14:
            begin
                if (ra < REG_LIMIT && rb <= REG_LIMIT && rc <= REG_LIMIT)
                    cls = CLS_READ_BC;
            end
            5'd5, 5'd6, 5'd12, 5'd15, 5'd22:
            begin
                if (ra < REG_LIMIT && rb <= REG_LIMIT)
                    cls = CLS_READ_B;
            end
            [5'd16:5'd21]:
            begin
                if (ra <= REG_LIMIT && rb <= REG_LIMIT && aligned)
                    cls = CLS_READ_AB;
            end
            OP_LOAD:
            begin
                if (ra < REG_LIMIT && aligned)
                    cls = CLS_WRITE_A;
            end
            OP_STORE:
            begin
                if (ra <= REG_LIMIT && aligned)
                    cls = CLS_READ_A;
            end
            OP_LOAD_IMM:
            begin
                if (ra < REG_LIMIT)
                    cls = CLS_WRITE_A;
            end
            OP_SYS:
            begin
                case (ext) inside
                    3'd0, 3'd2:
                    begin
                        if (ra < REG_LIMIT)
                            cls = CLS_WRITE_A;
                    end
                    3'd1, 3'd3:
                    begin
                        if (ra <= REG_LIMIT)
                            cls = CLS_READ_A;
                    end
                    SYS_HALT: cls = CLS_HALT;
                    default:  cls = CLS_INVALID;
                endcase
            end
            default: cls = CLS_INVALID;
        endcase
    end

    // Check reads against the map before this word's own write lands.
    always_comb
    begin
        case (cls)
            CLS_READ_BC: reads_ok = marked[rb] && marked[rc];
            CLS_READ_B:  reads_ok = marked[rb];
            CLS_READ_AB: reads_ok = marked[ra] && marked[rb];
            CLS_READ_A:  reads_ok = marked[ra];
            default:     reads_ok = 1'b1;
        endcase

        if (pos_reg >= LIMIT)
            status = ST_TOO_LONG;
        else if (cls == CLS_INVALID)
            status = ST_INVALID;
        else if (!reads_ok)
            status = ST_UNSET;
        else
            status = ST_OK;
    end

    // Next program state; a last word drops everything back to reset.
    always_comb
    begin
        map_next    = map_reg;
        pos_next    = pos_reg;
        failed_next = failed_reg;
        first_next  = first_reg;

        if ((cls == CLS_READ_BC || cls == CLS_READ_B || cls == CLS_WRITE_A)
            && ra <= REG_LIMIT)
            map_next[ra[2:0]] = 1'b1;

        if (status != ST_OK && !failed_reg)
        begin
            failed_next = 1'b1;
            first_next  = pos_reg;
        end

        if (pos_reg < LIMIT)
            pos_next = pos_reg + CNT_W'(1);
    end

    assign idx_wide   = {{INDEX_W{1'b0}}, pos_reg};
    assign first_wide = {{INDEX_W{1'b0}}, first_next};

    always_comb
    begin
        out_next.usage_class     = cls;
        out_next.word_status     = status;
        out_next.word_index      = idx_wide[INDEX_W-1:0];
        out_next.program_ok      = !failed_next;
        out_next.first_bad_index = failed_next ? first_wide[INDEX_W-1:0] : '0;
        out_next.program_done    = in_word_reg.last_word;
    end

    // Input register: load whenever it is empty or its beat moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_valid_reg || out_free)
            in_valid_reg <= word_valid;
    end

    always_ff @(posedge clk)
    begin
        if (word_valid && !word_stall)
            in_word_reg <= word;
    end

    // Result register and program state advance together.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            map_reg       <= '0;
            pos_reg       <= '0;
            failed_reg    <= 1'b0;
            first_reg     <= '0;
        end
        else
        begin
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (advance)
            begin
                if (in_word_reg.last_word)
                begin
                    map_reg    <= '0;
                    pos_reg    <= '0;
                    failed_reg <= 1'b0;
                    first_reg  <= '0;
                end
                else
                begin
                    map_reg    <= map_next;
                    pos_reg    <= pos_next;
                    failed_reg <= failed_next;
                    first_reg  <= first_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    // Any failing word must leave the sticky result cleared.
    a_fail_clears_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.word_status != ST_OK |-> !result.program_ok)
        else $error("failing word reported with program_ok set");

    // An invalid-word status only comes with the invalid class.
    a_invalid_class: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.word_status == ST_INVALID
        |-> result.usage_class == CLS_INVALID)
        else $error("invalid status on a classified word");

    // While the program is ok the first failing index reads zero.
    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.program_ok |-> result.first_bad_index == '0)
        else $error("first_bad_index set while program_ok");

    // A stalled result leaves the program state untouched.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && result_valid && result_stall
        |=> $stable(map_reg) && $stable(pos_reg) && $stable(failed_reg))
        else $error("program state moved during a stall");
`endif

endmodule

>>> verif/tb_instruction_def_before_use_checker_unit.sv
`timescale 1ns / 1ps

module tb_instruction_def_before_use_checker_unit;

    import idbu_pkg::*;

    localparam int MAX_WORDS = 4096;

    // Opcode groups as bit masks indexed by opcode.
    // Three-register ops: 0-4, 7-11, 13, 14.  Two-register ops: 5, 6, 12, 15, 22.
    // Compares: 16-21.
    localparam logic [31:0] THREE_REG_OPS = 32'h0000_6F9F;
    localparam logic [31:0] TWO_REG_OPS   = 32'h0040_9060;
    localparam logic [31:0] COMPARE_OPS   = 32'h003F_0000;

    // Named opcodes at the group edges, used by the directed beats
    localparam logic [4:0] OP_RRR_FIRST    = 5'd0;
    localparam logic [4:0] OP_RRR_LAST     = 5'd14;
    localparam logic [4:0] OP_RR_FIRST     = 5'd5;
    localparam logic [4:0] OP_RR_LAST      = 5'd22;
    localparam logic [4:0] OP_CMP_FIRST    = 5'd16;
    localparam logic [4:0] OP_CMP_LAST     = 5'd21;
    localparam logic [4:0] OP_UNUSED_FIRST = 5'd27;

    // System call extensions; masks are indexed by extension
    localparam logic [2:0] SYS_SET_A      = 3'd0;
    localparam logic [2:0] SYS_USE_A      = 3'd1;
    localparam logic [2:0] SYS_SET_A_ALT  = 3'd2;
    localparam logic [2:0] SYS_USE_A_ALT  = 3'd3;
    localparam logic [2:0] SYS_EXT_UNUSED = 3'd5;
    localparam logic [7:0] SYS_SET_EXTS   = 8'b0000_0101;
    localparam logic [7:0] SYS_USE_EXTS   = 8'b0000_1010;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    word_valid = 1'b0;
    logic    word_stall;
    word_t   word = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Words waiting to be offered, and results owed by the block in beat order
    word_t   pending_words[$];
    result_t expected_results[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;

    // Shadow of the block's program state
    logic [NUM_REGS-1:0] written_regs = '0;
    logic [INDEX_W-1:0]  word_pos = '0;
    logic                prog_failed = 1'b0;
    logic [INDEX_W-1:0]  first_fail_pos = '0;

    instruction_def_before_use_checker_unit #(
        .MAX_PROGRAM_WORDS(MAX_WORDS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .word_valid(word_valid),
        .word_stall(word_stall),
        .word(word),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Decode one word into its register usage class
    function automatic logic [2:0] usage_of(logic [31:0] w);
        logic [4:0] op;
        logic [2:0] ext;
        logic [2:0] ra;
        logic [2:0] rb;
        logic [2:0] rc;
        logic       aligned;
        op = w[31:27];
        ext = w[26:24];
        ra = w[23:21];
        rb = w[20:18];
        rc = w[17:15];
        aligned = (w[1:0] == 2'b00);
        if (op > OP_SYS)
            return CLS_INVALID;
        if (THREE_REG_OPS[op])
            return (ra < REG_LIMIT && rb <= REG_LIMIT && rc <= REG_LIMIT) ? CLS_READ_BC
                                                                           : CLS_INVALID;
        if (TWO_REG_OPS[op])
            return (ra < REG_LIMIT && rb <= REG_LIMIT) ? CLS_READ_B : CLS_INVALID;
        if (COMPARE_OPS[op])
            return (ra <= REG_LIMIT && rb <= REG_LIMIT && aligned) ? CLS_READ_AB : CLS_INVALID;
        if (op == OP_LOAD)
            return (ra < REG_LIMIT && aligned) ? CLS_WRITE_A : CLS_INVALID;
        if (op == OP_STORE)
            return (ra <= REG_LIMIT && aligned) ? CLS_READ_A : CLS_INVALID;
        if (op == OP_LOAD_IMM)
            return (ra < REG_LIMIT) ? CLS_WRITE_A : CLS_INVALID;
        // Only the system call is left
        if (SYS_SET_EXTS[ext])
            return (ra < REG_LIMIT) ? CLS_WRITE_A : CLS_INVALID;
        if (SYS_USE_EXTS[ext])
            return (ra <= REG_LIMIT) ? CLS_READ_A : CLS_INVALID;
        if (ext == SYS_HALT)
            return CLS_HALT;
        return CLS_INVALID;
    endfunction

    function automatic logic reg_written(logic [2:0] r);
        if (r > REG_LIMIT)
            return 1'b0;
        return written_regs[r];
    endfunction

    // Work out the result for one accepted word and advance the shadow state
    function automatic result_t predict_result(word_t w);
        result_t             r;
        logic [2:0]          cls;
        logic [2:0]          ra;
        logic [2:0]          rb;
        logic [2:0]          rc;
        logic                reads_ok;
        logic [1:0]          st;
        logic [INDEX_W-1:0]  idx;
        cls = usage_of(w.instruction_word);
        ra = w.instruction_word[23:21];
        rb = w.instruction_word[20:18];
        rc = w.instruction_word[17:15];
        idx = word_pos;

        // Check reads against the map before this word's own write lands
        case (cls)
            CLS_READ_BC: reads_ok = reg_written(rb) && reg_written(rc);
            CLS_READ_B:  reads_ok = reg_written(rb);
            CLS_READ_AB: reads_ok = reg_written(ra) && reg_written(rb);
            CLS_READ_A:  reads_ok = reg_written(ra);
            default:     reads_ok = 1'b1;
        endcase

        // Too long outranks invalid, which outranks an unset read
        if (idx >= MAX_WORDS)
            st = ST_TOO_LONG;
        else if (cls == CLS_INVALID)
            st = ST_INVALID;
        else if (!reads_ok)
            st = ST_UNSET;
        else
            st = ST_OK;

        // A valid writer marks its target even when its own reads failed
        if ((cls == CLS_READ_BC || cls == CLS_READ_B || cls == CLS_WRITE_A) && ra <= REG_LIMIT)
            written_regs[ra] = 1'b1;

        // Keep only the first failure of the program
        if (st != ST_OK && !prog_failed)
        begin
            prog_failed = 1'b1;
            first_fail_pos = idx;
        end

        if (word_pos < MAX_WORDS)
            word_pos = word_pos + 1'b1;

        r.usage_class = cls;
        r.word_status = st;
        r.word_index = idx;
        r.program_ok = !prog_failed;
        r.first_bad_index = prog_failed ? first_fail_pos : '0;
        r.program_done = w.last_word;

        // The end of a program clears everything
        if (w.last_word)
        begin
            written_regs = '0;
            word_pos = '0;
            prog_failed = 1'b0;
            first_fail_pos = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Driver: predict on each accepted beat, then offer the next word or idle.
    // A held beat is never touched while the block stalls it.
    always @(posedge clk)
    begin : word_driver
        if (rst_n)
        begin
            if (word_valid && !word_stall)
                expected_results.push_back(predict_result(word));
            if (!word_valid || !word_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    word <= pending_words.pop_front();
                    word_valid <= 1'b1;
                end
                else
                begin
                    word_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random and compare each accepted result beat with the
    // oldest expectation
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n)
        begin
            result_stall <= ($urandom_range(99) < stall_pct);
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no expectation waiting");
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("usage_class", want.usage_class, result.usage_class);
                    check_field("word_status", want.word_status, result.word_status);
                    check_field("word_index", want.word_index, result.word_index);
                    check_field("program_ok", want.program_ok, result.program_ok);
                    check_field("first_bad_index", want.first_bad_index,
                                result.first_bad_index);
                    check_field("program_done", want.program_done, result.program_done);
                end
            end
        end
    end

    function automatic logic [31:0] encode(logic [4:0] op, logic [2:0] ext, logic [2:0] ra,
                                           logic [2:0] rb, logic [2:0] rc, logic [14:0] lit);
        return {op, ext, ra, rb, rc, lit};
    endfunction

    task automatic add_word(input logic [31:0] w, input logic last);
        word_t item;
        item.instruction_word = w;
        item.last_word = last;
        pending_words.push_back(item);
    endtask

    // Mostly pick a register that the program has already written, so that
    // long runs of words get past the read check
    function automatic logic [2:0] pick_source(logic [6:0] made);
        logic [2:0] r;
        if (made == '0 || $urandom_range(9) == 0)
            return 3'($urandom_range(7, 0));
        r = 3'($urandom_range(6, 0));
        while (!made[r])
            r = 3'($urandom_range(6, 0));
        return r;
    endfunction

    // Queue one program: a quarter loads that set registers, most of the rest
    // random ops reading set registers, and some raw noise words
    task automatic queue_program(input int len, input logic close);
        logic [6:0]  made;
        logic [4:0]  op;
        logic [2:0]  ra;
        logic [31:0] w;
        int          roll;
        made = '0;
        for (int i = 0; i < len; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 25)
            begin
                ra = 3'($urandom_range(5, 0));
                op = ($urandom_range(1) != 0) ? OP_LOAD_IMM : OP_LOAD;
                w = {op, 3'($urandom()), ra, 21'($urandom())};
                w[1:0] = 2'b00;
                made[ra] = 1'b1;
            end
            else if (roll < 88)
            begin
                op = 5'($urandom_range(OP_SYS, 0));
                ra = pick_source(made);
                w = {op, 3'($urandom()), ra, pick_source(made), pick_source(made),
                     15'($urandom())};
                if ($urandom_range(4) != 0)
                    w[1:0] = 2'b00;
                if ((THREE_REG_OPS[op] || TWO_REG_OPS[op]) && ra < REG_LIMIT)
                    made[ra] = 1'b1;
            end
            else
            begin
                w = $urandom();
            end
            add_word(w, close && (i == len - 1));
        end
    endtask

    task automatic queue_random_programs(input int count);
        int queued;
        int len;
        queued = 0;
        while (queued < count)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(12, 1);
            queue_program(len, 1'b1);
            queued += len;
        end
    endtask

    // Hold off until every queued word is accepted and every result has come
    task automatic drain;
        while (pending_words.size() != 0 || word_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(negedge clk);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed program: extremes of the word, each opcode group, the
        // alignment checks, the used system call extensions and an unused one,
        // own write and a failing word that still marks its target
        add_word(32'h0000_0000, 1'b0);
        add_word(encode(OP_LOAD_IMM, 3'd0, 3'd6, 3'd0, 3'd0, 15'h7FFF), 1'b0);
        add_word(encode(OP_LOAD_IMM, 3'd7, 3'd5, 3'd7, 3'd7, 15'h7FFF), 1'b0);
        add_word(encode(OP_SYS, SYS_SET_A, 3'd1, 3'd0, 3'd0, 15'h0000), 1'b0);
        add_word(encode(OP_SYS, SYS_SET_A_ALT, 3'd2, 3'd0, 3'd0, 15'h0000), 1'b0);
        add_word(encode(OP_RRR_LAST, 3'd0, 3'd3, 3'd0, 3'd2, 15'h0000), 1'b0);
        add_word(encode(OP_RR_FIRST, 3'd0, 3'd4, 3'd5, 3'd7, 15'h0000), 1'b0);
        add_word(encode(OP_CMP_FIRST, 3'd0, 3'd6, 3'd4, 3'd0, 15'h0004), 1'b0);
        add_word(encode(OP_CMP_LAST, 3'd0, 3'd3, 3'd4, 3'd0, 15'h0002), 1'b0);
        add_word(encode(OP_LOAD, 3'd0, 3'd6, 3'd0, 3'd0, 15'h0000), 1'b0);
        add_word(encode(OP_LOAD, 3'd0, 3'd0, 3'd0, 3'd0, 15'h0003), 1'b0);
        add_word(encode(OP_STORE, 3'd0, 3'd6, 3'd0, 3'd0, 15'h0008), 1'b0);
        add_word(encode(OP_STORE, 3'd0, 3'd5, 3'd0, 3'd0, 15'h0001), 1'b0);
        add_word(encode(OP_SYS, SYS_USE_A, 3'd7, 3'd0, 3'd0, 15'h0000), 1'b0);
        add_word(encode(OP_SYS, SYS_USE_A_ALT, 3'd5, 3'd0, 3'd0, 15'h0000), 1'b0);
        add_word(encode(OP_SYS, SYS_HALT, 3'd7, 3'd7, 3'd7, 15'h7FFF), 1'b0);
        add_word(encode(OP_SYS, SYS_EXT_UNUSED, 3'd0, 3'd0, 3'd0, 15'h0000), 1'b0);
        add_word(encode(OP_UNUSED_FIRST, 3'd0, 3'd0, 3'd0, 3'd0, 15'h0000), 1'b0);
        add_word(32'hFFFF_FFFF, 1'b1);
        // The map must be clear again: an unset read, then a clean one-word program
        add_word(encode(OP_RR_LAST, 3'd0, 3'd0, 3'd0, 3'd0, 15'h0000), 1'b1);
        add_word(encode(OP_LOAD_IMM, 3'd0, 3'd0, 3'd0, 3'd0, 15'h0000), 1'b1);
        drain();

        // A program that opens on an invalid word and a read of register 7,
        // then carries on with ordinary words
        add_word(32'hFFFF_FFFF, 1'b0);
        add_word(encode(OP_RRR_FIRST, 3'd0, 3'd0, 3'd7, 3'd7, 15'h0000), 1'b0);
        queue_program(3, 1'b1);
        drain();

        // Random programs under each idling pattern; drain between phases
        queue_random_programs(130);
        drain();
        set_idling(84, 0);
        queue_random_programs(130);
        drain();
        set_idling(0, 84);
        queue_random_programs(130);
        drain();
        set_idling(35, 35);
        queue_random_programs(130);
        drain();

        // Allow for anything the block might still push out
        repeat (10) @(negedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
